/* hdl/dmsp_pkg.sv */
// Shared types, constants and helper functions for the DMS coordinate parser.
package dmsp_pkg;

	// Field widths of the result and of the parse state.
	localparam int unsigned LatW    = 20;
	localparam int unsigned LonW    = 21;
	localparam int unsigned LonMagW = 22;
	localparam int unsigned PosW    = 5;
	localparam int unsigned FieldW  = 7;
	localparam int unsigned LonDegW = 10;

	// Character positions within the fixed token form DDMMSSXDDDMMSSY.
	localparam logic [PosW-1:0] TokenLen   = 5'd15;
	localparam logic [PosW-1:0] PosSat     = 5'd16;
	localparam logic [PosW-1:0] LatHemiPos = 5'd6;
	localparam logic [PosW-1:0] LonHemiPos = 5'd14;
	localparam logic [PosW-1:0] LatDegEnd  = 5'd1;
	localparam logic [PosW-1:0] LatMinEnd  = 5'd3;
	localparam logic [PosW-1:0] LatSecEnd  = 5'd5;
	localparam logic [PosW-1:0] LonDegEnd  = 5'd9;
	localparam logic [PosW-1:0] LonMinEnd  = 5'd11;

	// ASCII codes that the form accepts.
	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;
	localparam logic [7:0] CharN    = 8'h4E;
	localparam logic [7:0] CharS    = 8'h53;
	localparam logic [7:0] CharE    = 8'h45;
	localparam logic [7:0] CharW    = 8'h57;

	// Range limits and arc-second scale factors.
	localparam logic [FieldW-1:0]  MinSecLimit = 7'd60;
	localparam logic [FieldW-1:0]  LatDegMax   = 7'd90;
	localparam logic [LonDegW-1:0] LonDegMax   = 10'd180;
	localparam logic [11:0]        SecPerDeg   = 12'd3600;
	localparam logic [5:0]         SecPerMin   = 6'd60;

	// Final parse state of one token, handed to the conversion stage.
	typedef struct packed {
		logic                 basic_ok;
		logic [FieldW-1:0]    lat_deg;
		logic [FieldW-1:0]    lat_min;
		logic [FieldW-1:0]    lat_sec;
		logic                 lat_south;
		logic [LonDegW-1:0]   lon_deg;
		logic [FieldW-1:0]    lon_min;
		logic [FieldW-1:0]    lon_sec;
		logic                 lon_west;
	} snap_t;

	// Appends one decimal digit to a 7-bit accumulator, wrapping at its width.
	function automatic logic [FieldW-1:0] push_digit7(input logic [FieldW-1:0] acc,
			input logic [3:0] d);
		push_digit7 = FieldW'((acc << 3) + (acc << 1) + FieldW'(d));
	endfunction

	// Appends one decimal digit to the 10-bit longitude degree accumulator.
	function automatic logic [LonDegW-1:0] push_digit10(input logic [LonDegW-1:0] acc,
			input logic [3:0] d);
		push_digit10 = LonDegW'((acc << 3) + (acc << 1) + LonDegW'(d));
	endfunction

endpackage

/* hdl/dms_coordinate_parser_top.sv */
// Top level of the DMS coordinate parser: input register and stage handshakes.
//
// Usage: the sender offers one ASCII character of a token per item on char_in,
// with last_char high on the token's final character, qualified by item_valid.
// The block checks the fixed form DDMMSSXDDDMMSSY and, for each token, returns
// one result item on the final character only: coord_valid, and latitude and
// longitude in signed whole arc-seconds (south and west negative, both zero
// when the token is malformed or out of range).
// Throughput is one item per cycle while item_stall is low; every character is
// taken in a single pass through the parse logic, limited by the per-character
// state update. From acceptance of the last character, its result passes in turn
// through the input register, the snapshot register and the result register
// before it reaches the result ports.
// Reset (arst_n low) empties every stage and clears the parse state, so the
// next character starts a new token. When the receiver holds result_stall,
// the result stays on the ports; characters keep being taken until the
// pipeline behind a waiting result fills, and then item_stall rises.
module dms_coordinate_parser_top import dmsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [7:0]             char_in,
	input  logic                   last_char,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   coord_valid,
	output logic signed [LatW-1:0] lat_arcsec,
	output logic signed [LonW-1:0] lon_arcsec
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       s1_go;
	logic       snap_ready;
	snap_t      snap;

	// A character leaves the input register at once, a last one when its slot is free.
	assign s1_go      = valid_s1 && (!last_s1 || snap_ready);
	assign item_stall = valid_s1 && !s1_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	dmsp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (s1_go),
		.char_s1 (char_s1),
		.last_s1 (last_s1),
		.snap    (snap)
	);

	dmsp_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap         (snap),
		.snap_valid   (s1_go && last_s1),
		.snap_ready   (snap_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.coord_valid  (coord_valid),
		.lat_arcsec   (lat_arcsec),
		.lon_arcsec   (lon_arcsec)
	);

endmodule

/* hdl/dmsp_parse.sv */
// Per-character parse state: position count, format check and digit accumulators.
module dmsp_parse import dmsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] char_s1,
	input  logic       last_s1,
	output snap_t      snap
);

	logic [PosW-1:0]    pos_q, pos_d;
	logic               err_q, err_d;
	logic [FieldW-1:0]  lat_deg_q, lat_deg_d;
	logic [FieldW-1:0]  lat_min_q, lat_min_d;
	logic [FieldW-1:0]  lat_sec_q, lat_sec_d;
	logic               south_q, south_d;
	logic [LonDegW-1:0] lon_deg_q, lon_deg_d;
	logic [FieldW-1:0]  lon_min_q, lon_min_d;
	logic [FieldW-1:0]  lon_sec_q, lon_sec_d;
	logic               west_q, west_d;
	logic               is_digit;
	logic [3:0]         digit;

	// A digit's value is the low nibble of its ASCII code.
	assign is_digit = (char_s1 >= CharZero) && (char_s1 <= CharNine);
	assign digit    = is_digit ? char_s1[3:0] : 4'd0;

	// Next state after taking the character in the input register.
	always_comb begin
		pos_d     = pos_q;
		err_d     = err_q;
		lat_deg_d = lat_deg_q;
		lat_min_d = lat_min_q;
		lat_sec_d = lat_sec_q;
		south_d   = south_q;
		lon_deg_d = lon_deg_q;
		lon_min_d = lon_min_q;
		lon_sec_d = lon_sec_q;
		west_d    = west_q;
		if (pos_q >= TokenLen) begin
			err_d = 1'b1;
		end else if (pos_q == LatHemiPos) begin
			if (char_s1 == CharN || char_s1 == CharS) begin
				south_d = (char_s1 == CharS);
			end else begin
				err_d = 1'b1;
			end
		end else if (pos_q == LonHemiPos) begin
			if (char_s1 == CharE || char_s1 == CharW) begin
				west_d = (char_s1 == CharW);
			end else begin
				err_d = 1'b1;
			end
		end else if (!is_digit) begin
			err_d = 1'b1;
		end else if (pos_q <= LatDegEnd) begin
			lat_deg_d = push_digit7(lat_deg_q, digit);
		end else if (pos_q <= LatMinEnd) begin
			lat_min_d = push_digit7(lat_min_q, digit);
		end else if (pos_q <= LatSecEnd) begin
			lat_sec_d = push_digit7(lat_sec_q, digit);
		end else if (pos_q <= LonDegEnd) begin
			lon_deg_d = push_digit10(lon_deg_q, digit);
		end else if (pos_q <= LonMinEnd) begin
			lon_min_d = push_digit7(lon_min_q, digit);
		end else begin
			lon_sec_d = push_digit7(lon_sec_q, digit);
		end
		pos_d = (pos_q < PosSat) ? pos_q + 5'd1 : PosSat;
	end

	// The token's final state, valid in the cycle its last character is taken.
	always_comb begin
		snap.basic_ok  = (pos_d == TokenLen) && !err_d;
		snap.lat_deg   = lat_deg_d;
		snap.lat_min   = lat_min_d;
		snap.lat_sec   = lat_sec_d;
		snap.lat_south = south_d;
		snap.lon_deg   = lon_deg_d;
		snap.lon_min   = lon_min_d;
		snap.lon_sec   = lon_sec_d;
		snap.lon_west  = west_d;
	end

	// State registers; the last character of a token returns them to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			err_q     <= 1'b0;
			lat_deg_q <= '0;
			lat_min_q <= '0;
			lat_sec_q <= '0;
			south_q   <= 1'b0;
			lon_deg_q <= '0;
			lon_min_q <= '0;
			lon_sec_q <= '0;
			west_q    <= 1'b0;
		end else if (byte_en) begin
			if (last_s1) begin
				pos_q     <= '0;
				err_q     <= 1'b0;
				lat_deg_q <= '0;
				lat_min_q <= '0;
				lat_sec_q <= '0;
				south_q   <= 1'b0;
				lon_deg_q <= '0;
				lon_min_q <= '0;
				lon_sec_q <= '0;
				west_q    <= 1'b0;
			end else begin
				pos_q     <= pos_d;
				err_q     <= err_d;
				lat_deg_q <= lat_deg_d;
				lat_min_q <= lat_min_d;
				lat_sec_q <= lat_sec_d;
				south_q   <= south_d;
				lon_deg_q <= lon_deg_d;
				lon_min_q <= lon_min_d;
				lon_sec_q <= lon_sec_d;
				west_q    <= west_d;
			end
		end
	end

endmodule

/* hdl/dmsp_convert.sv */
// Range check and arc-second conversion of a finished token, with the result register.
module dmsp_convert import dmsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  snap_t                  snap,
	input  logic                   snap_valid,
	output logic                   snap_ready,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   coord_valid,
	output logic signed [LatW-1:0] lat_arcsec,
	output logic signed [LonW-1:0] lon_arcsec
);

	snap_t               snap_s2;
	logic                valid_s2;
	logic                out_valid_q;
	logic                ok_q;
	logic [LatW-1:0]     lat_q;
	logic [LonW-1:0]     lon_q;
	logic                out_ready;
	logic                ok;
	logic [LatW-1:0]     lat_mag;
	logic [LonMagW-1:0]  lon_mag;
	logic [LatW-1:0]     lat_val;
	logic [LonW-1:0]     lon_val;

	// The result register frees when empty or taken; the snapshot stage follows it.
	assign out_ready  = !out_valid_q || !result_stall;
	assign snap_ready = !valid_s2 || out_ready;

	// Snapshot register for the token that just finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (snap_ready) begin
			valid_s2 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			snap_s2 <= snap;
		end
	end

	// Range checks and arc-second sums.
	always_comb begin
		ok = snap_s2.basic_ok
			&& (snap_s2.lat_min < MinSecLimit) && (snap_s2.lat_sec < MinSecLimit)
			&& (snap_s2.lon_min < MinSecLimit) && (snap_s2.lon_sec < MinSecLimit)
			&& (snap_s2.lat_deg <= LatDegMax) && (snap_s2.lon_deg <= LonDegMax);
		lat_mag = LatW'(snap_s2.lat_deg) * LatW'(SecPerDeg)
			+ LatW'(snap_s2.lat_min) * LatW'(SecPerMin) + LatW'(snap_s2.lat_sec);
		lon_mag = LonMagW'(snap_s2.lon_deg) * LonMagW'(SecPerDeg)
			+ LonMagW'(snap_s2.lon_min) * LonMagW'(SecPerMin) + LonMagW'(snap_s2.lon_sec);
		lat_val = snap_s2.lat_south ? -lat_mag : lat_mag;
		lon_val = snap_s2.lon_west ? -lon_mag[LonW-1:0] : lon_mag[LonW-1:0];
	end

	// Result register; an invalid token reports zero coordinates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			ok_q  <= ok;
			lat_q <= ok ? lat_val : '0;
			lon_q <= ok ? lon_val : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign coord_valid  = ok_q;
	assign lat_arcsec   = $signed(lat_q);
	assign lon_arcsec   = $signed(lon_q);

endmodule

/* hdl/dmsp_checker.sv */
// Port-level checks on the DMS coordinate parser, bound to the top level.
module dmsp_checker import dmsp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_stall,
	input logic                   coord_valid,
	input logic signed [LatW-1:0] lat_arcsec,
	input logic signed [LonW-1:0] lon_arcsec
);

	// A stalled result item stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	// A rejected token carries zero coordinates.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !coord_valid |-> lat_arcsec == 0 && lon_arcsec == 0)
		else $error("invalid token with non-zero coordinates");

	// A valid latitude lies within ninety degrees plus 59 arc-minutes and 59 arc-seconds.
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && coord_valid
		|-> lat_arcsec <= 20'sd327599 && lat_arcsec >= -20'sd327599)
		else $error("latitude out of range");

	// A valid longitude lies within one hundred and eighty degrees likewise.
	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && coord_valid
		|-> lon_arcsec <= 21'sd651599 && lon_arcsec >= -21'sd651599)
		else $error("longitude out of range");

endmodule

bind dms_coordinate_parser_top dmsp_checker u_checker (.*);
